@@ rtl/core/sse_pkg.sv @@
// shared types, constants and helpers of the event stream parser
package sse_pkg;

	localparam int CNT_W = 24;
	localparam logic [CNT_W-1:0] MAX_EVENT_RESET = 24'd8388608;

	localparam int RETRY_W = 64;
	// accumulated retry values never exceed the signed maximum
	localparam int RACC_W = 63;

	localparam logic [3:0] TK_DATA_BYTE = 4'd0;
	localparam logic [3:0] TK_DATA_BREAK = 4'd1;
	localparam logic [3:0] TK_TYPE_BEGIN = 4'd2;
	localparam logic [3:0] TK_TYPE_BYTE = 4'd3;
	localparam logic [3:0] TK_ID_BEGIN = 4'd4;
	localparam logic [3:0] TK_ID_BYTE = 4'd5;
	localparam logic [3:0] TK_DISPATCH = 4'd6;
	localparam logic [3:0] TK_DISCARD = 4'd7;
	localparam logic [3:0] TK_ERROR = 4'd8;

	localparam logic [7:0] CH_BOM0 = 8'hEF;
	localparam logic [7:0] CH_BOM1 = 8'hBB;
	localparam logic [7:0] CH_BOM2 = 8'hBF;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// field name slots: data, event, id, retry
	localparam logic [1:0] FN_DATA = 2'd0;
	localparam logic [1:0] FN_EVENT = 2'd1;
	localparam logic [1:0] FN_ID = 2'd2;
	localparam logic [1:0] FN_RETRY = 2'd3;
	localparam logic [2:0] NAME_LEN [4] = '{3'd4, 3'd5, 3'd2, 3'd5};

	typedef struct packed {
		logic                     valid;
		logic [3:0]               kind;
		logic [7:0]               byte_value;
		logic                     id_seen;
		logic                     type_given;
		logic [RETRY_W-1:0]       retry_value;
	} result_t;

	function automatic logic [7:0] name_char(logic [1:0] k, logic [2:0] idx);
		logic [7:0] c;
		c = CH_NUL;
		unique case (k)
			FN_DATA: begin
				unique case (idx)
					3'd0: c = "d";
					3'd1: c = "a";
					3'd2: c = "t";
					3'd3: c = "a";
					default: c = CH_NUL;
				endcase
			end
			FN_EVENT: begin
				unique case (idx)
					3'd0: c = "e";
					3'd1: c = "v";
					3'd2: c = "e";
					3'd3: c = "n";
					3'd4: c = "t";
					default: c = CH_NUL;
				endcase
			end
			FN_ID: begin
				unique case (idx)
					3'd0: c = "i";
					3'd1: c = "d";
					default: c = CH_NUL;
				endcase
			end
			default: begin
				unique case (idx)
					3'd0: c = "r";
					3'd1: c = "e";
					3'd2: c = "t";
					3'd3: c = "r";
					3'd4: c = "y";
					default: c = CH_NUL;
				endcase
			end
		endcase
		return c;
	endfunction

	// drop the candidates that the next name byte rules out
	function automatic logic [3:0] name_match(logic [3:0] cand, logic [2:0] nlen,
		logic [7:0] b);
		logic [3:0] r;
		r = cand;
		for (int k = 0; k < 4; k++) begin
			if (nlen >= NAME_LEN[k] || name_char(2'(k), nlen) != b)
				r[k] = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/sse_event_stream_parser.sv @@
// top level of the server-sent events stream parser
// Takes one stream byte per cycle while the output is not stalled and gives
// at most one token per byte; the sustained rate of one byte per clock is set
// by the combinational step logic that sits between the input register and
// the result register. A byte's token, if any, passes through the input
// register and then the result register; bytes that cause no token leave no
// trace on the output. Input is held back only while a finished token waits
// at the output. The user must write the event size limit over the cfg channel
// only while the parser is idle; the block itself does not enforce this. An
// error token is given once and the parser then stays silent until reset.
module sse_event_stream_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // stream_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [79:0]               m_tdata,   // byte_value, id_seen, type_given, retry_value, zero pad
	output logic [3:0]                m_tuser,   // token_kind
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sse_pkg::CNT_W-1:0] cfg_data   // max_event_bytes
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_free;
	logic             step_en;
	sse_pkg::result_t res;

	assign cfg_ready = 1'b1;
	assign step_en = valid_s1 && out_free;

	sse_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (out_free),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_max (cfg_data),
		.step_en (step_en),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	sse_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ rtl/core/sse_in_stage.sv @@
// input register stage of the event stream parser
module sse_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // stream_byte
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

@@ rtl/core/sse_core.sv @@
// parser state and the per-byte step logic
module sse_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [sse_pkg::CNT_W-1:0] cfg_max,
	input  logic                      step_en,
	input  logic [7:0]                byte_s1,
	output sse_pkg::result_t          res
);

	localparam logic [2:0] MODE_START = 3'd0;
	localparam logic [2:0] MODE_NAME = 3'd1;
	localparam logic [2:0] MODE_COMMENT = 3'd2;
	localparam logic [2:0] MODE_OTHER = 3'd3;
	localparam logic [2:0] MODE_DATA = 3'd4;
	localparam logic [2:0] MODE_TYPE = 3'd5;
	localparam logic [2:0] MODE_ID = 3'd6;
	localparam logic [2:0] MODE_RETRY = 3'd7;

	localparam logic [1:0] BOM_DONE = 2'd3;

	logic [sse_pkg::CNT_W-1:0]   max_q, cnt_q, n_cnt;
	logic [2:0]                  mode_q, n_mode;
	logic [3:0]                  cand_q, n_cand;
	logic [2:0]                  nlen_q, n_nlen;
	logic                        strip_q, n_strip;
	logic                        cr_q, n_cr;
	logic [1:0]                  bom_q, n_bom;
	logic                        data_q, n_data;
	logic                        idl_q, n_idl;
	logic                        typl_q, n_typl;
	logic [sse_pkg::RACC_W-1:0]  racc_q, n_racc;
	logic                        rval_q, n_rval;
	logic [sse_pkg::RACC_W-1:0]  evr_q, n_evr;
	logic                        evr_none_q, n_evr_none;
	logic                        failed_q, n_failed;

	logic [7:0]                  b;
	logic [7:0]                  bom_char;
	logic                        go, do_fs, eol, skip;
	logic [3:0]                  digit;
	logic [sse_pkg::RACC_W+3:0]  prod;

	assign b = byte_s1;
	assign digit = 4'(b - sse_pkg::CH_ZERO);
	// acc * 10 + digit, fits in four extra bits
	assign prod = {racc_q, 3'b000} + {2'b00, racc_q, 1'b0} + {63'd0, digit};

	always_comb begin
		unique case (bom_q)
			2'd0: bom_char = sse_pkg::CH_BOM0;
			2'd1: bom_char = sse_pkg::CH_BOM1;
			default: bom_char = sse_pkg::CH_BOM2;
		endcase
	end

	always_comb begin
		n_cnt = cnt_q;
		n_mode = mode_q;
		n_cand = cand_q;
		n_nlen = nlen_q;
		n_strip = strip_q;
		n_cr = cr_q;
		n_bom = bom_q;
		n_data = data_q;
		n_idl = idl_q;
		n_typl = typl_q;
		n_racc = racc_q;
		n_rval = rval_q;
		n_evr = evr_q;
		n_evr_none = evr_none_q;
		n_failed = failed_q;
		go = 1'b0;
		do_fs = 1'b0;
		eol = 1'b0;
		skip = 1'b0;
		res = '0;
		res.retry_value = '1;

		if (failed_q) begin
			go = 1'b0;
		end else if (cnt_q >= max_q) begin
			n_failed = 1'b1;
			res.valid = 1'b1;
			res.kind = sse_pkg::TK_ERROR;
		end else begin
			n_cnt = cnt_q + 1'b1;
			go = 1'b1;
			if (bom_q != BOM_DONE) begin
				if (b == bom_char) begin
					n_bom = bom_q + 1'b1;
					go = 1'b0;
				end else begin
					// a broken mark starts an unknown field name
					if (bom_q != 2'd0) begin
						n_mode = MODE_NAME;
						n_cand = 4'd0;
						n_nlen = {1'b0, bom_q};
					end
					n_bom = BOM_DONE;
				end
			end
		end

		if (go) begin
			n_cr = 1'b0;
			if (b == sse_pkg::CH_LF && cr_q) begin
				go = 1'b0;
			end else if (b == sse_pkg::CH_CR || b == sse_pkg::CH_LF) begin
				n_cr = (b == sse_pkg::CH_CR);
				eol = 1'b1;
				if (n_mode == MODE_START) begin
					res.valid = 1'b1;
					res.id_seen = idl_q;
					if (data_q) begin
						res.kind = sse_pkg::TK_DISPATCH;
						res.type_given = typl_q;
						res.retry_value = evr_none_q ? '1 : {1'b0, evr_q};
					end else begin
						res.kind = sse_pkg::TK_DISCARD;
					end
					n_data = 1'b0;
					n_idl = 1'b0;
					n_typl = 1'b0;
					n_evr_none = 1'b1;
					n_cnt = '0;
				end else if (n_mode == MODE_NAME) begin
					do_fs = 1'b1;
				end else if (n_mode == MODE_RETRY && rval_q) begin
					n_evr = racc_q;
					n_evr_none = 1'b0;
				end
			end else begin
				unique case (n_mode)
					MODE_START: begin
						if (b == sse_pkg::CH_COLON) begin
							n_mode = MODE_COMMENT;
						end else begin
							n_mode = MODE_NAME;
							n_cand = sse_pkg::name_match(4'hF, 3'd0, b);
							n_nlen = 3'd1;
						end
					end
					MODE_NAME: begin
						if (b == sse_pkg::CH_COLON) begin
							do_fs = 1'b1;
						end else begin
							n_cand = sse_pkg::name_match(n_cand, n_nlen, b);
							if (n_nlen != 3'd7)
								n_nlen = n_nlen + 1'b1;
						end
					end
					MODE_COMMENT: begin
						skip = 1'b1;
					end
					default: begin
						if (strip_q) begin
							n_strip = 1'b0;
							skip = (b == sse_pkg::CH_SPACE);
						end
						if (!skip) begin
							if (b == sse_pkg::CH_NUL) begin
								n_failed = 1'b1;
								res.valid = 1'b1;
								res.kind = sse_pkg::TK_ERROR;
							end else begin
								unique case (n_mode)
									MODE_DATA: begin
										res.valid = 1'b1;
										res.kind = sse_pkg::TK_DATA_BYTE;
										res.byte_value = b;
									end
									MODE_TYPE: begin
										res.valid = 1'b1;
										res.kind = sse_pkg::TK_TYPE_BYTE;
										res.byte_value = b;
									end
									MODE_ID: begin
										res.valid = 1'b1;
										res.kind = sse_pkg::TK_ID_BYTE;
										res.byte_value = b;
									end
									MODE_RETRY: begin
										if (b >= sse_pkg::CH_ZERO && b <= sse_pkg::CH_NINE &&
											prod[sse_pkg::RACC_W+3:sse_pkg::RACC_W] == 4'd0) begin
											n_racc = prod[sse_pkg::RACC_W-1:0];
											n_rval = 1'b1;
										end else begin
											n_rval = 1'b0;
											n_mode = MODE_OTHER;
										end
									end
									default: begin
										skip = 1'b1;
									end
								endcase
							end
						end
					end
				endcase
			end
		end

		// field name ended: enter its value mode, or skip the value of an unknown name
		if (do_fs) begin
			n_strip = 1'b1;
			if (n_cand[sse_pkg::FN_DATA] && n_nlen == sse_pkg::NAME_LEN[sse_pkg::FN_DATA]) begin
				if (data_q) begin
					res.valid = 1'b1;
					res.kind = sse_pkg::TK_DATA_BREAK;
				end
				n_data = 1'b1;
				n_mode = MODE_DATA;
			end else if (n_cand[sse_pkg::FN_EVENT] &&
				n_nlen == sse_pkg::NAME_LEN[sse_pkg::FN_EVENT]) begin
				n_typl = 1'b1;
				n_mode = MODE_TYPE;
				res.valid = 1'b1;
				res.kind = sse_pkg::TK_TYPE_BEGIN;
			end else if (n_cand[sse_pkg::FN_ID] && n_nlen == sse_pkg::NAME_LEN[sse_pkg::FN_ID]) begin
				n_idl = 1'b1;
				n_mode = MODE_ID;
				res.valid = 1'b1;
				res.kind = sse_pkg::TK_ID_BEGIN;
			end else if (n_cand[sse_pkg::FN_RETRY] &&
				n_nlen == sse_pkg::NAME_LEN[sse_pkg::FN_RETRY]) begin
				n_racc = '0;
				n_rval = 1'b0;
				n_mode = MODE_RETRY;
			end else begin
				n_mode = MODE_OTHER;
			end
		end

		if (eol) begin
			n_mode = MODE_START;
			n_strip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= sse_pkg::MAX_EVENT_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mode_q <= MODE_START;
			cand_q <= 4'hF;
			nlen_q <= 3'd0;
			strip_q <= 1'b0;
			cr_q <= 1'b0;
			bom_q <= 2'd0;
			data_q <= 1'b0;
			idl_q <= 1'b0;
			typl_q <= 1'b0;
			racc_q <= '0;
			rval_q <= 1'b0;
			evr_q <= '0;
			evr_none_q <= 1'b1;
			failed_q <= 1'b0;
		end else if (step_en) begin
			cnt_q <= n_cnt;
			mode_q <= n_mode;
			cand_q <= n_cand;
			nlen_q <= n_nlen;
			strip_q <= n_strip;
			cr_q <= n_cr;
			bom_q <= n_bom;
			data_q <= n_data;
			idl_q <= n_idl;
			typl_q <= n_typl;
			racc_q <= n_racc;
			rval_q <= n_rval;
			evr_q <= n_evr;
			evr_none_q <= n_evr_none;
			failed_q <= n_failed;
		end
	end

	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("failure flag cleared without reset");

	a_error_sets_failed: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res.valid && res.kind == sse_pkg::TK_ERROR) |=> failed_q)
		else $error("error token without failure flag");

	a_silent_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && failed_q) |-> !res.valid)
		else $error("token produced after failure");

	a_retry_only_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind != sse_pkg::TK_DISPATCH) |-> res.retry_value == '1)
		else $error("retry value on a token other than dispatch");

endmodule

@@ rtl/core/sse_out_stage.sv @@
// result register of the event stream parser
module sse_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  sse_pkg::result_t res,
	output logic             out_free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [79:0]      m_tdata,   // byte_value, id_seen, type_given, retry_value, zero pad
	output logic [3:0]       m_tuser    // token_kind
);

	logic [7:0]                   byte_q;
	logic                         id_q;
	logic                         type_q;
	logic [sse_pkg::RETRY_W-1:0]  retry_q;
	logic [3:0]                   kind_q;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= step_en && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step_en && res.valid) begin
			byte_q <= res.byte_value;
			id_q <= res.id_seen;
			type_q <= res.type_given;
			retry_q <= res.retry_value;
			kind_q <= res.kind;
		end
	end

	assign m_tdata = {6'd0, retry_q, type_q, id_q, byte_q};
	assign m_tuser = kind_q;

endmodule

@@ dv/tb_sse_event_stream_parser.sv @@
// testbench for the server-sent events stream parser: directed table, random events, checker
`timescale 1ns / 100ps

module tb_sse_event_stream_parser;

	localparam int QUIET_LIMIT = 5000;
	localparam int N_ROWS = 13;
	localparam logic [sse_pkg::RETRY_W-1:0] NO_RETRY = '1;
	localparam logic [sse_pkg::RETRY_W-1:0] RETRY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		LM_START, LM_NAME, LM_COMMENT, LM_OTHER, LM_DATA, LM_TYPE, LM_ID, LM_RETRY
	} line_mode_e;

	typedef struct packed {
		logic [3:0]                  kind;
		logic [7:0]                  bval;
		logic                        id_seen;
		logic                        type_given;
		logic [sse_pkg::RETRY_W-1:0] retry;
	} token_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [7:0]                s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [79:0]               m_tdata;   // byte_value, id_seen, type_given, retry_value, zero pad
	logic [3:0]                m_tuser;   // token_kind
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [sse_pkg::CNT_W-1:0] cfg_data = '0;

	// typed expectation that rides along with the byte on the input bus
	bit                  row_pin = 1'b0;
	token_t              row_tok = '0;

	int                  idle_pct = 0;
	int                  stall_pct = 0;
	int                  n_bad = 0;
	int                  quiet_cycles = 0;
	token_t              token_q [$];
	logic [7:0]          burst [$];

	// parser shadow state
	line_mode_e                  lmode = LM_START;
	logic [3:0]                  cand = 4'hF;
	logic [2:0]                  nlen = '0;
	bit                          strip_sp = 1'b0;
	bit                          cr_prev = 1'b0;
	logic [1:0]                  bom_cnt = '0;
	bit                          ev_data = 1'b0;
	bit                          ev_id = 1'b0;
	bit                          ev_type = 1'b0;
	logic [sse_pkg::RETRY_W-1:0] racc = '0;
	bit                          racc_ok = 1'b0;
	logic [sse_pkg::RETRY_W-1:0] ev_retry = '1;
	int unsigned                 ev_bytes = 0;
	logic [sse_pkg::CNT_W-1:0]   ev_limit = sse_pkg::MAX_EVENT_RESET;
	bit                          dead = 1'b0;

	string field_name [4] = '{"data", "event", "id", "retry"};
	string odd_names [8] = '{"dat", "datas", "even", "eventt", "i", "idd", "retr", "Data"};

	string row_text [N_ROWS] = '{
		"\n",
		"\n",
		"data: A\015\n",
		"data\015",
		"\015",
		"event:\377\nid\n",
		":c\377\nretry:9223372036854775807\n",
		"retry:9223372036854775808\nretry: 1a\nretry\n",
		"data:\n",
		"dat:q\nidd\n",
		"\n",
		"id:7\n\n",
		"data:a\ndata: b\nevent:m\nevent\n\n"
	};
	bit row_pinned [N_ROWS] = '{0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 1, 1, 0};
	token_t row_want [N_ROWS] = '{
		'0,
		'{sse_pkg::TK_DISCARD, 8'h00, 1'b0, 1'b0, NO_RETRY},
		'0,
		'0,
		'{sse_pkg::TK_DISPATCH, 8'h00, 1'b0, 1'b0, NO_RETRY},
		'0,
		'0,
		'0,
		'0,
		'0,
		'{sse_pkg::TK_DISPATCH, 8'h00, 1'b1, 1'b1, RETRY_MAX},
		'{sse_pkg::TK_DISCARD, 8'h00, 1'b1, 1'b0, NO_RETRY},
		'0
	};

	sse_event_stream_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic token_t mk_tok(logic [3:0] k, logic [7:0] v, logic i, logic ty,
		logic [sse_pkg::RETRY_W-1:0] r);
		token_t t;
		t.kind = k;
		t.bval = v;
		t.id_seen = i;
		t.type_given = ty;
		t.retry = r;
		return t;
	endfunction

	task automatic name_step(input logic [7:0] b);
		for (int k = 0; k < 4; k++) begin
			if (nlen >= field_name[k].len() || field_name[k][nlen] != b)
				cand[k] = 1'b0;
		end
		if (nlen < 3'd7)
			nlen++;
	endtask

	function automatic bit name_hit(logic [1:0] k);
		return cand[k] && nlen == field_name[k].len();
	endfunction

	task automatic field_begin(output bit got, output token_t t);
		got = 1'b0;
		t = '0;
		strip_sp = 1'b1;
		if (name_hit(sse_pkg::FN_DATA)) begin
			if (ev_data) begin
				got = 1'b1;
				t = mk_tok(sse_pkg::TK_DATA_BREAK, 8'h00, 1'b0, 1'b0, NO_RETRY);
			end
			ev_data = 1'b1;
			lmode = LM_DATA;
		end else if (name_hit(sse_pkg::FN_EVENT)) begin
			ev_type = 1'b1;
			lmode = LM_TYPE;
			got = 1'b1;
			t = mk_tok(sse_pkg::TK_TYPE_BEGIN, 8'h00, 1'b0, 1'b0, NO_RETRY);
		end else if (name_hit(sse_pkg::FN_ID)) begin
			ev_id = 1'b1;
			lmode = LM_ID;
			got = 1'b1;
			t = mk_tok(sse_pkg::TK_ID_BEGIN, 8'h00, 1'b0, 1'b0, NO_RETRY);
		end else if (name_hit(sse_pkg::FN_RETRY)) begin
			racc = '0;
			racc_ok = 1'b0;
			lmode = LM_RETRY;
		end else begin
			lmode = LM_OTHER;
		end
	endtask

	task automatic close_line(output bit got, output token_t t);
		got = 1'b0;
		t = '0;
		if (lmode == LM_START) begin
			got = 1'b1;
			if (ev_data)
				t = mk_tok(sse_pkg::TK_DISPATCH, 8'h00, ev_id, ev_type, ev_retry);
			else
				t = mk_tok(sse_pkg::TK_DISCARD, 8'h00, ev_id, 1'b0, NO_RETRY);
			ev_data = 1'b0;
			ev_id = 1'b0;
			ev_type = 1'b0;
			ev_retry = NO_RETRY;
			ev_bytes = 0;
		end else if (lmode == LM_NAME) begin
			field_begin(got, t);
		end else if (lmode == LM_RETRY && racc_ok) begin
			ev_retry = racc;
		end
		lmode = LM_START;
		strip_sp = 1'b0;
	endtask

	// one stream byte through the shadow parser; at most one token
	task automatic parse_stream_byte(input logic [7:0] b, output bit got, output token_t t);
		logic [7:0]                  mark;
		logic [sse_pkg::RETRY_W-1:0] d;
		bit                          was_cr;
		got = 1'b0;
		t = '0;
		if (dead)
			return;
		if (ev_bytes >= ev_limit) begin
			dead = 1'b1;
			got = 1'b1;
			t = mk_tok(sse_pkg::TK_ERROR, 8'h00, 1'b0, 1'b0, NO_RETRY);
			return;
		end
		ev_bytes++;
		if (bom_cnt < 2'd3) begin
			mark = (bom_cnt == 2'd0) ? sse_pkg::CH_BOM0 :
				(bom_cnt == 2'd1) ? sse_pkg::CH_BOM1 : sse_pkg::CH_BOM2;
			if (b == mark) begin
				bom_cnt++;
				return;
			end
			// partial mark turns into the start of an unknown name
			if (bom_cnt > 2'd0) begin
				lmode = LM_NAME;
				cand = 4'h0;
				nlen = {1'b0, bom_cnt};
			end
			bom_cnt = 2'd3;
		end
		was_cr = cr_prev;
		cr_prev = 1'b0;
		if (b == sse_pkg::CH_LF && was_cr)
			return;
		if (b == sse_pkg::CH_CR || b == sse_pkg::CH_LF) begin
			cr_prev = (b == sse_pkg::CH_CR);
			close_line(got, t);
			return;
		end
		case (lmode)
			LM_START: begin
				if (b == sse_pkg::CH_COLON) begin
					lmode = LM_COMMENT;
				end else begin
					lmode = LM_NAME;
					cand = 4'hF;
					nlen = '0;
					name_step(b);
				end
				return;
			end
			LM_NAME: begin
				if (b == sse_pkg::CH_COLON)
					field_begin(got, t);
				else
					name_step(b);
				return;
			end
			LM_COMMENT: return;
			default: ;
		endcase
		if (strip_sp) begin
			strip_sp = 1'b0;
			if (b == sse_pkg::CH_SPACE)
				return;
		end
		if (b == sse_pkg::CH_NUL) begin
			dead = 1'b1;
			got = 1'b1;
			t = mk_tok(sse_pkg::TK_ERROR, 8'h00, 1'b0, 1'b0, NO_RETRY);
			return;
		end
		case (lmode)
			LM_DATA: begin
				got = 1'b1;
				t = mk_tok(sse_pkg::TK_DATA_BYTE, b, 1'b0, 1'b0, NO_RETRY);
			end
			LM_TYPE: begin
				got = 1'b1;
				t = mk_tok(sse_pkg::TK_TYPE_BYTE, b, 1'b0, 1'b0, NO_RETRY);
			end
			LM_ID: begin
				got = 1'b1;
				t = mk_tok(sse_pkg::TK_ID_BYTE, b, 1'b0, 1'b0, NO_RETRY);
			end
			LM_RETRY: begin
				if (b >= sse_pkg::CH_ZERO && b <= sse_pkg::CH_NINE) begin
					d = sse_pkg::RETRY_W'(b - sse_pkg::CH_ZERO);
					// overflow past the signed maximum drops the whole line
					if (racc > (RETRY_MAX - d) / 10) begin
						racc_ok = 1'b0;
						lmode = LM_OTHER;
					end else begin
						racc = racc * 10 + d;
						racc_ok = 1'b1;
					end
				end else begin
					racc_ok = 1'b0;
					lmode = LM_OTHER;
				end
			end
			default: ;
		endcase
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] seen);
		n_bad++;
		if (n_bad <= 10)
			$display("mismatch in %s: expected %0h, got %0h", what, want, seen);
	endtask

	bit     new_got;
	token_t new_tok;
	token_t seen_tok;
	token_t want_tok;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen_tok = mk_tok(m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[73:10]);
				if (token_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected token of kind %0d", seen_tok.kind);
				end else begin
					want_tok = token_q.pop_front();
					if (seen_tok.kind != want_tok.kind)
						note_mismatch("token_kind", want_tok.kind, seen_tok.kind);
					if (seen_tok.bval != want_tok.bval)
						note_mismatch("byte_value", want_tok.bval, seen_tok.bval);
					if (seen_tok.id_seen != want_tok.id_seen)
						note_mismatch("id_seen", want_tok.id_seen, seen_tok.id_seen);
					if (seen_tok.type_given != want_tok.type_given)
						note_mismatch("type_given", want_tok.type_given, seen_tok.type_given);
					if (seen_tok.retry != want_tok.retry)
						note_mismatch("retry_value", want_tok.retry, seen_tok.retry);
				end
			end
			if (s_tvalid && s_tready) begin
				parse_stream_byte(s_tdata, new_got, new_tok);
				if (row_pin)
					token_q.push_back(row_tok);
				else if (new_got)
					token_q.push_back(new_tok);
			end
			if (cfg_valid && cfg_ready)
				ev_limit = cfg_data;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[sse_event_stream_parser] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit pin, input token_t tok);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		row_pin <= pin;
		row_tok <= tok;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic set_limit(input logic [sse_pkg::CNT_W-1:0] v);
		s_tvalid <= 1'b0;
		// let the checker log the last transaction first
		@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
		// bytes that give no token may still be in the pipeline
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			burst.push_back(s[i]);
	endtask

	task automatic add_eol();
		case ($urandom_range(2))
			0: burst.push_back(sse_pkg::CH_LF);
			1: burst.push_back(sse_pkg::CH_CR);
			default: begin
				burst.push_back(sse_pkg::CH_CR);
				burst.push_back(sse_pkg::CH_LF);
			end
		endcase
	endtask

	// nul_ok is set for names and comments only, where a zero byte is harmless
	task automatic add_value(input int n, input bit nul_ok);
		logic [7:0] v;
		repeat (n) begin
			v = nul_ok ? 8'($urandom_range(255)) : 8'($urandom_range(1, 255));
			if (v == sse_pkg::CH_CR || v == sse_pkg::CH_LF || (nul_ok && v == sse_pkg::CH_COLON))
				v = sse_pkg::CH_SPACE;
			burst.push_back(v);
		end
	endtask

	task automatic add_digits(input int n);
		repeat (n)
			burst.push_back(sse_pkg::CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic add_field(input string name);
		add_text(name);
		if ($urandom_range(9) != 0) begin
			add_text(":");
			if ($urandom_range(1))
				add_text(" ");
			add_value($urandom_range(0, 10), 1'b0);
		end
	endtask

	task automatic add_retry();
		add_text("retry:");
		if ($urandom_range(1))
			add_text(" ");
		case ($urandom_range(5))
			0: add_digits($urandom_range(1, 19));
			1: add_text("9223372036854775807");
			2: add_text("9223372036854775808");
			3: add_digits($urandom_range(20, 22));
			4: begin
				add_digits($urandom_range(0, 4));
				add_value(1, 1'b0);
				add_digits($urandom_range(0, 4));
			end
			default: ;
		endcase
	endtask

	task automatic build_event();
		burst.delete();
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(9))
				0, 1, 2: add_field("data");
				3: add_field("event");
				4: add_field("id");
				5: add_retry();
				6: begin
					add_text(":");
					add_value($urandom_range(0, 8), 1'b1);
				end
				7: begin
					if ($urandom_range(3) == 0)
						add_value($urandom_range(1, 6), 1'b1);
					else
						add_text(odd_names[$urandom_range(7)]);
					add_text(":");
					add_value($urandom_range(0, 6), 1'b0);
				end
				8: repeat ($urandom_range(1, 10)) burst.push_back(8'($urandom_range(1, 255)));
				default: add_text(field_name[$urandom_range(3)]);
			endcase
			add_eol();
		end
		// most events close with a blank line, some run on into the next
		if ($urandom_range(99) < 85)
			add_eol();
	endtask

	task automatic run_phase(input int idle_p, input int stall_p, input int n_bytes);
		int sent;
		idle_pct = idle_p;
		stall_pct = stall_p;
		sent = 0;
		while (sent < n_bytes) begin
			build_event();
			// keep run-on events well below the size limit
			if (ev_bytes + 200 > ev_limit) begin
				burst.push_front(sse_pkg::CH_LF);
				burst.push_front(sse_pkg::CH_LF);
			end
			foreach (burst[i])
				send_byte(burst[i], 1'b0, '0);
			sent += burst.size();
		end
		send_byte(sse_pkg::CH_LF, 1'b0, '0);
		send_byte(sse_pkg::CH_LF, 1'b0, '0);
	endtask

	initial begin
		int last;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_limit(sse_pkg::MAX_EVENT_RESET);

		// byte order mark at the head of the stream: whole, or broken after one or two bytes
		case ($urandom_range(2))
			0: begin
				send_byte(sse_pkg::CH_BOM0, 1'b0, '0);
				send_byte(sse_pkg::CH_BOM1, 1'b0, '0);
				send_byte(sse_pkg::CH_BOM2, 1'b0, '0);
			end
			1: begin
				send_byte(sse_pkg::CH_BOM0, 1'b0, '0);
				send_byte(sse_pkg::CH_BOM1, 1'b0, '0);
				send_byte("x", 1'b0, '0);
			end
			default: begin
				send_byte(sse_pkg::CH_BOM0, 1'b0, '0);
				send_byte("a", 1'b0, '0);
			end
		endcase
		for (int r = 0; r < N_ROWS; r++) begin
			last = row_text[r].len() - 1;
			for (int i = 0; i <= last; i++)
				send_byte(row_text[r][i], row_pinned[r] && i == last, row_want[r]);
		end

		run_phase(0, 0, 325);
		set_limit(24'd1000);
		run_phase(54, 0, 325);
		set_limit(sse_pkg::CNT_W'($urandom_range(1000, 8388608)));
		run_phase(0, 54, 325);
		set_limit(24'd4096);
		run_phase(25, 25, 325);

		// smallest limit: lone blank lines still fit
		set_limit(24'd1);
		repeat (3)
			send_byte(sse_pkg::CH_LF, 1'b1,
				mk_tok(sse_pkg::TK_DISCARD, 8'h00, 1'b0, 1'b0, NO_RETRY));
		if ($urandom_range(1)) begin
			set_limit(sse_pkg::MAX_EVENT_RESET);
			burst.delete();
			add_text("data: ab");
			foreach (burst[i])
				send_byte(burst[i], 1'b0, '0);
			send_byte(sse_pkg::CH_NUL, 1'b1,
				mk_tok(sse_pkg::TK_ERROR, 8'h00, 1'b0, 1'b0, NO_RETRY));
		end else begin
			send_byte("a", 1'b0, '0);
			send_byte("b", 1'b1, mk_tok(sse_pkg::TK_ERROR, 8'h00, 1'b0, 1'b0, NO_RETRY));
		end
		// parser stays silent once failed
		repeat (20)
			send_byte(8'($urandom_range(255)), 1'b0, '0);
		s_tvalid <= 1'b0;

		while (token_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_bad == 0)
			$display("[sse_event_stream_parser] OK");
		else
			$display("[sse_event_stream_parser] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/sse_pkg.sv
rtl/core/sse_in_stage.sv
rtl/core/sse_core.sv
rtl/core/sse_out_stage.sv
rtl/core/sse_event_stream_parser.sv
dv/tb_sse_event_stream_parser.sv
